### rtl/lcbb_pkg.sv
// Shared types and constants for the byte-budgeted LRU table.
`default_nettype none
package lcbb_pkg;

  typedef struct packed {
    logic        operation;
    logic [63:0] key_tag;
    logic [63:0] identity_tag;
    logic [39:0] file_size;
  } lcbb_in_t;

  typedef struct packed {
    logic        hit;
    logic        stale;
    logic [7:0]  slot_index;
    logic [8:0]  evicted_count;
    logic [8:0]  entry_count;
    logic [47:0] total_bytes;
  } lcbb_out_t;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_INSERT = 1'b1;

  localparam logic CFG_ENTRY_LIMIT = 1'b0;
  localparam logic CFG_BYTE_BUDGET = 1'b1;

  localparam logic [8:0]  ENTRY_LIMIT_RST = 9'd256;
  localparam logic [47:0] BYTE_BUDGET_RST = 48'd67108864;

  typedef enum logic [3:0] {
    S_IDLE,
    S_FIND,
    S_TOUCH,
    S_DROP,
    S_CHKFULL,
    S_EVICT,
    S_INC,
    S_WRITE,
    S_TRIM,
    S_FIN
  } lcbb_state_t;

endpackage
`default_nettype wire

### rtl/lru_cache_with_byte_budget_core.sv
// LRU table bounded by entry count and byte budget, stored in one slot memory.
//
// Input channel in_valid/in_stall/in_data: one request (lookup or insert) per
// transfer. Result channel out_valid/out_stall/out_data: exactly one result per
// request, in order. The user must issue configuration writes (cfg_we, cfg_index,
// cfg_data) only while no request is in flight; the block does not enforce this.
// Every request walks the slot memory with one read per cycle. A lookup takes
// one walk on a miss and two on a present key. An insert takes two walks (find,
// age all ranks), a third when it replaces a present key, plus one walk per
// evicted entry.
// One request is processed at a time; the next one is accepted as soon as the
// result sits in the output register, even if that register is still stalled.
// A stalled result holds until taken; processing of the next request stops at
// its end until the output register is free.
// Synchronous reset clears all valid bits, the count, the byte total and
// restores the limits (256 entries, 64 MiB); no memory clearing pass is needed.
`default_nettype none
module lru_cache_with_byte_budget_core
  import lcbb_pkg::*;
#(
  parameter int ENTRIES   = 256,
  parameter int KEY_BITS  = 64,
  parameter int SIZE_BITS = 40
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire lcbb_in_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output lcbb_out_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [47:0] cfg_data
);

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int TOT_W = (SIZE_BITS + CNT_W > 48) ? SIZE_BITS + CNT_W : 49;
  localparam int LIM_W = (CNT_W > 9) ? CNT_W : 9;

  typedef struct packed {
    logic [KEY_BITS-1:0]  key;
    logic [63:0]          ident;
    logic [SIZE_BITS-1:0] size;
    logic [IDX_W-1:0]     rank;
  } entry_t;

  entry_t mem [ENTRIES];
  entry_t rd_data_r;

  lcbb_state_t state_r, state_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             pend_r, pend_nxt;
  logic [IDX_W-1:0] pend_addr_r, pend_addr_nxt;

  logic                 op_r;
  logic [KEY_BITS-1:0]  key_r;
  logic [63:0]          ident_r;
  logic [SIZE_BITS-1:0] size_r;

  logic                 found_r, found_nxt;
  logic                 idm_r, idm_nxt;
  logic                 free_r, free_nxt;
  logic                 trim_r, trim_nxt;
  logic [IDX_W-1:0]     slot_r, slot_nxt;
  logic [IDX_W-1:0]     rank_r, rank_nxt;
  logic [SIZE_BITS-1:0] dsize_r, dsize_nxt;
  logic [CNT_W-1:0]     evict_r, evict_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [TOT_W-1:0]     total_r, total_nxt;
  logic [ENTRIES-1:0]   valid_r, valid_nxt;

  logic [8:0]  entry_limit_r;
  logic [47:0] byte_budget_r;

  logic      out_valid_r, out_valid_nxt;
  lcbb_out_t out_data_r, out_data_nxt;

  logic             mem_we;
  logic [IDX_W-1:0] mem_wa;
  entry_t           mem_wd;
  logic             rd_en;

  logic             in_acc;
  logic             cur_v;
  logic             sweep_done;
  logic [LIM_W-1:0] limit0, limit_eff;
  logic [47:0]      fsize48;
  logic [IDX_W+8:0] slot_ext;
  logic [CNT_W+9:0] evict_ext, count_ext;

  assign in_acc     = in_valid && !in_stall;
  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign cur_v      = valid_r[pend_addr_r];
  assign sweep_done = (idx_r == CNT_W'(ENTRIES)) && !pend_r;
  assign rd_en      = (idx_r != CNT_W'(ENTRIES));
  assign limit0     = LIM_W'(entry_limit_r);
  assign limit_eff  = (limit0 < LIM_W'(ENTRIES)) ? limit0 : LIM_W'(ENTRIES);
  assign fsize48    = {8'd0, in_data.file_size};
  assign slot_ext   = {9'd0, slot_r};
  assign evict_ext  = {10'd0, evict_r};
  assign count_ext  = {10'd0, count_r};

  // Slot memory: one read and one write port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_data_r <= mem[idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r    <= in_data.operation;
      key_r   <= in_data.key_tag[KEY_BITS-1:0];
      ident_r <= in_data.identity_tag;
      size_r  <= fsize48[SIZE_BITS-1:0];
    end
    out_data_r  <= out_data_nxt;
    idx_r       <= idx_nxt;
    pend_addr_r <= pend_addr_nxt;
    found_r     <= found_nxt;
    idm_r       <= idm_nxt;
    free_r      <= free_nxt;
    trim_r      <= trim_nxt;
    slot_r      <= slot_nxt;
    rank_r      <= rank_nxt;
    dsize_r     <= dsize_nxt;
    evict_r     <= evict_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      pend_r        <= 1'b0;
      count_r       <= '0;
      total_r       <= '0;
      valid_r       <= '0;
      out_valid_r   <= 1'b0;
      entry_limit_r <= ENTRY_LIMIT_RST;
      byte_budget_r <= BYTE_BUDGET_RST;
    end else begin
      state_r     <= state_nxt;
      pend_r      <= pend_nxt;
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      valid_r     <= valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ENTRY_LIMIT: entry_limit_r <= cfg_data[8:0];
          CFG_BYTE_BUDGET: byte_budget_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    pend_nxt      = 1'b0;
    pend_addr_nxt = idx_r[IDX_W-1:0];
    found_nxt     = found_r;
    idm_nxt       = idm_r;
    free_nxt      = free_r;
    trim_nxt      = trim_r;
    slot_nxt      = slot_r;
    rank_nxt      = rank_r;
    dsize_nxt     = dsize_r;
    evict_nxt     = evict_r;
    count_nxt     = count_r;
    total_nxt     = total_r;
    valid_nxt     = valid_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_wa        = pend_addr_r;
    mem_wd        = rd_data_r;

    // Advance the walk in every sweep state.
    if (state_r == S_FIND || state_r == S_TOUCH || state_r == S_DROP ||
        state_r == S_EVICT || state_r == S_INC) begin
      if (rd_en) begin
        idx_nxt  = idx_r + 1'b1;
        pend_nxt = 1'b1;
      end
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_FIND;
          idx_nxt   = '0;
          found_nxt = 1'b0;
          idm_nxt   = 1'b0;
          evict_nxt = '0;
          slot_nxt  = '0;
        end
      end
      S_FIND: begin
        if (pend_r && cur_v && rd_data_r.key == key_r && !found_r) begin
          found_nxt = 1'b1;
          slot_nxt  = pend_addr_r;
          rank_nxt  = rd_data_r.rank;
          dsize_nxt = rd_data_r.size;
          idm_nxt   = (rd_data_r.ident == ident_r);
        end
        if (sweep_done) begin
          idx_nxt = '0;
          if (op_r == OP_LOOKUP) begin
            state_nxt = found_r ? S_TOUCH : S_FIN;
          end else begin
            state_nxt = found_r ? S_DROP : S_CHKFULL;
          end
        end
      end
      S_TOUCH: begin
        if (pend_r && cur_v) begin
          if (pend_addr_r == slot_r) begin
            mem_we      = 1'b1;
            mem_wd.rank = '0;
          end else if (rd_data_r.rank < rank_r) begin
            mem_we      = 1'b1;
            mem_wd.rank = rd_data_r.rank + 1'b1;
          end
        end
        if (sweep_done) begin
          state_nxt = S_FIN;
        end
      end
      S_DROP: begin
        if (pend_r && cur_v) begin
          if (pend_addr_r == slot_r) begin
            valid_nxt[pend_addr_r] = 1'b0;
          end else if (rd_data_r.rank > rank_r) begin
            mem_we      = 1'b1;
            mem_wd.rank = rd_data_r.rank - 1'b1;
          end
        end
        if (sweep_done) begin
          count_nxt = count_r - 1'b1;
          total_nxt = total_r - TOT_W'(dsize_r);
          state_nxt = S_CHKFULL;
        end
      end
      S_CHKFULL: begin
        idx_nxt  = '0;
        trim_nxt = 1'b0;
        free_nxt = 1'b0;
        state_nxt = (count_r == CNT_W'(ENTRIES)) ? S_EVICT : S_INC;
      end
      S_EVICT: begin
        // Drop the single entry holding the oldest rank.
        if (pend_r && cur_v && CNT_W'(rd_data_r.rank) == count_r - 1'b1) begin
          valid_nxt[pend_addr_r] = 1'b0;
          total_nxt = total_r - TOT_W'(rd_data_r.size);
        end
        if (sweep_done) begin
          count_nxt = count_r - 1'b1;
          evict_nxt = evict_r + 1'b1;
          idx_nxt   = '0;
          state_nxt = trim_r ? S_TRIM : S_INC;
        end
      end
      S_INC: begin
        if (pend_r) begin
          if (cur_v) begin
            mem_we      = 1'b1;
            mem_wd.rank = rd_data_r.rank + 1'b1;
          end else if (!free_r) begin
            free_nxt = 1'b1;
            slot_nxt = pend_addr_r;
          end
        end
        if (sweep_done) begin
          if (!free_r) begin
            slot_nxt = free_r ? slot_r : '0;
          end
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        mem_we        = 1'b1;
        mem_wa        = slot_r;
        mem_wd.key    = key_r;
        mem_wd.ident  = ident_r;
        mem_wd.size   = size_r;
        mem_wd.rank   = '0;
        valid_nxt[slot_r] = 1'b1;
        count_nxt     = count_r + 1'b1;
        total_nxt     = total_r + TOT_W'(size_r);
        trim_nxt      = 1'b1;
        state_nxt     = S_TRIM;
      end
      S_TRIM: begin
        idx_nxt = '0;
        if (count_r > CNT_W'(1) &&
            (LIM_W'(count_r) > limit_eff || total_r > TOT_W'(byte_budget_r))) begin
          state_nxt = S_EVICT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.hit           = (op_r == OP_LOOKUP) && found_r && idm_r;
          out_data_nxt.stale         = (op_r == OP_LOOKUP) && found_r && !idm_r;
          out_data_nxt.slot_index    = slot_ext[7:0];
          out_data_nxt.evicted_count = evict_ext[8:0];
          out_data_nxt.entry_count   = count_ext[8:0];
          out_data_nxt.total_bytes   = (|total_r[TOT_W-1:48]) ? '1 : total_r[47:0];
          state_nxt                  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  a_count_matches_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (CNT_W'($countones(valid_r)) == count_r))
    else $error("held count disagrees with valid bits");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(ENTRIES))
    else $error("held count above table size");

  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && count_r == '0) |-> (total_r == '0))
    else $error("byte total nonzero on empty table");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !pend_r)
    else $error("memory walk left pending in idle");

endmodule
`default_nettype wire
